FILE: rtl/nutm_pkg.sv
// Shared constants and types for the nearest unused tile match block.
package nutm_pkg;

  localparam int DEF_MAX_TILES      = 256;
  localparam int DEF_MAX_COMPONENTS = 48;
  localparam int DEF_SUM_WIDTH      = 20;

  localparam int OP_W          = 1;
  localparam int TILE_SLOT_W   = 8;
  localparam int COMP_INDEX_W  = 6;
  localparam int VALUE_W       = 20;
  localparam int TILE_COUNT_W  = 9;
  localparam int COMP_COUNT_W  = 6;
  localparam int SCORE_W       = 26;
  localparam int CFG_DATA_W    = 26;
  localparam int CFG_INDEX_W   = 2;

  localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_TILE_COUNT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMP_COUNT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCORE_LIMIT = 2'd2;

  localparam logic [TILE_COUNT_W-1:0] RST_TILE_COUNT  = 9'd0;
  localparam logic [COMP_COUNT_W-1:0] RST_COMP_COUNT  = 6'd12;
  localparam logic [SCORE_W-1:0]      RST_SCORE_LIMIT = 26'd306000;

  // Commands from controller to datapath.
  typedef struct packed {
    logic accept;   // input beat taken this cycle
    logic start;    // search begins: load best with the limit
    logic rd_en;    // issue one component read
    logic first;    // first component of a tile
    logic last;     // last component of a tile
    logic zero;     // no components: score is zero
    logic publish;  // move result to output, mark winner used
  } nutm_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic used_cur;  // tile under the walk pointer is already used
    logic busy;      // compare pipeline still holds work
    logic out_free;  // output register can take a result
  } nutm_stat_t;

  // Flags that travel down the compare pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic zero;
  } nutm_tag_t;

endpackage

FILE: rtl/nearest_unused_tile_match.sv
// Top level of the nearest unused tile match block.
// Load beats and query beats are taken one per cycle while in_stall is low.
// The query beat with last set starts a search that holds in_stall high: the
// controller walks tiles 0 to tile_count-1 (capped at MAX_TILES-1) and reads
// one signature component per cycle of each unused tile from the signature
// RAM. The result waits while out_stall still holds the previous one in the
// output register. The lowest-index unused tile with the strictly smallest
// sum of absolute differences below score_limit wins, is marked used and is
// reported; otherwise found is 0 and best_tile is 0. Used marks sit in
// flip-flops cleared by reset, so no clearing pass is needed. Configuration
// writes must only happen while idle.
module nearest_unused_tile_match #(
  parameter int MAX_TILES      = nutm_pkg::DEF_MAX_TILES,
  parameter int MAX_COMPONENTS = nutm_pkg::DEF_MAX_COMPONENTS,
  parameter int SUM_WIDTH      = nutm_pkg::DEF_SUM_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [nutm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [nutm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [nutm_pkg::OP_W-1:0]          op,
  input  logic [nutm_pkg::TILE_SLOT_W-1:0]   tile_slot,
  input  logic [nutm_pkg::COMP_INDEX_W-1:0]  component_index,
  input  logic [nutm_pkg::VALUE_W-1:0]       value,
  input  logic                               last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               found,
  output logic [nutm_pkg::TILE_SLOT_W-1:0]   best_tile
);

  import nutm_pkg::*;

  localparam int TILE_W  = $clog2(MAX_TILES);
  localparam int TILE_CW = $clog2(MAX_TILES + 1);
  localparam int COMP_W  = $clog2(MAX_COMPONENTS);
  localparam int COMP_CW = $clog2(MAX_COMPONENTS + 1);

  nutm_cmd_t            cmd;
  nutm_stat_t           stat;
  logic [TILE_W-1:0]    rd_tile;
  logic [COMP_W-1:0]    rd_comp;
  logic [TILE_CW-1:0]   tiles;
  logic [COMP_CW-1:0]   comps;

  nutm_ctrl #(
    .MAX_TILES      (MAX_TILES),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .last     (last),
    .stat     (stat),
    .tiles    (tiles),
    .comps    (comps),
    .in_stall (in_stall),
    .cmd      (cmd),
    .rd_tile  (rd_tile),
    .rd_comp  (rd_comp)
  );

  nutm_dp #(
    .MAX_TILES      (MAX_TILES),
    .MAX_COMPONENTS (MAX_COMPONENTS),
    .SUM_WIDTH      (SUM_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .op              (op),
    .tile_slot       (tile_slot),
    .component_index (component_index),
    .value           (value),
    .cmd             (cmd),
    .rd_tile         (rd_tile),
    .rd_comp         (rd_comp),
    .stat            (stat),
    .tiles           (tiles),
    .comps           (comps),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .found           (found),
    .best_tile       (best_tile)
  );

endmodule

FILE: rtl/nutm_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module nutm_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/nutm_ctrl.sv
// Controller: accepts beats, walks tiles and components during a search.
module nutm_ctrl #(
  parameter int MAX_TILES      = nutm_pkg::DEF_MAX_TILES,
  parameter int MAX_COMPONENTS = nutm_pkg::DEF_MAX_COMPONENTS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  input  logic [nutm_pkg::OP_W-1:0]               op,
  input  logic                                    last,
  input  nutm_pkg::nutm_stat_t                    stat,
  input  logic [$clog2(MAX_TILES+1)-1:0]          tiles,
  input  logic [$clog2(MAX_COMPONENTS+1)-1:0]     comps,
  output logic                                    in_stall,
  output nutm_pkg::nutm_cmd_t                     cmd,
  output logic [$clog2(MAX_TILES)-1:0]            rd_tile,
  output logic [$clog2(MAX_COMPONENTS)-1:0]       rd_comp
);

  import nutm_pkg::*;

  localparam int TILE_W  = $clog2(MAX_TILES);
  localparam int TILE_CW = $clog2(MAX_TILES + 1);
  localparam int COMP_W  = $clog2(MAX_COMPONENTS);
  localparam int COMP_CW = $clog2(MAX_COMPONENTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN
  } state_t;

  state_t               state;
  logic [TILE_CW-1:0]   t;
  logic [COMP_CW-1:0]   k;
  logic                 walk_done;
  logic                 no_comps;
  logic                 tile_end;

  assign walk_done = (t == tiles);
  assign no_comps  = (comps == '0);
  assign tile_end  = no_comps || (k == comps - COMP_CW'(1));

  assign in_stall = (state != S_IDLE);
  assign rd_tile  = t[TILE_W-1:0];
  assign rd_comp  = k[COMP_W-1:0];

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        cmd.start  = in_valid && (op == OP_QUERY) && last;
      end
      S_WALK: begin
        if (!walk_done && !stat.used_cur) begin
          cmd.rd_en = 1'b1;
          cmd.first = (k == '0);
          cmd.last  = tile_end;
          cmd.zero  = no_comps;
        end
      end
      S_DRAIN: begin
        cmd.publish = !stat.busy && stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      t     <= '0;
      k     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.start) begin
            state <= S_WALK;
            t     <= '0;
            k     <= '0;
          end
        end
        S_WALK: begin
          if (walk_done) begin
            state <= S_DRAIN;
          end else if (stat.used_cur || tile_end) begin
            t <= t + TILE_CW'(1);
            k <= '0;
          end else begin
            k <= k + COMP_CW'(1);
          end
        end
        S_DRAIN: begin
          if (cmd.publish) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/nutm_dp.sv
// Datapath: config registers, signature and query RAMs, SAD pipeline, result.
module nutm_dp #(
  parameter int MAX_TILES      = nutm_pkg::DEF_MAX_TILES,
  parameter int MAX_COMPONENTS = nutm_pkg::DEF_MAX_COMPONENTS,
  parameter int SUM_WIDTH      = nutm_pkg::DEF_SUM_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [nutm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [nutm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [nutm_pkg::OP_W-1:0]             op,
  input  logic [nutm_pkg::TILE_SLOT_W-1:0]      tile_slot,
  input  logic [nutm_pkg::COMP_INDEX_W-1:0]     component_index,
  input  logic [nutm_pkg::VALUE_W-1:0]          value,
  input  nutm_pkg::nutm_cmd_t                   cmd,
  input  logic [$clog2(MAX_TILES)-1:0]          rd_tile,
  input  logic [$clog2(MAX_COMPONENTS)-1:0]     rd_comp,
  output nutm_pkg::nutm_stat_t                  stat,
  output logic [$clog2(MAX_TILES+1)-1:0]        tiles,
  output logic [$clog2(MAX_COMPONENTS+1)-1:0]   comps,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  found,
  output logic [nutm_pkg::TILE_SLOT_W-1:0]      best_tile
);

  import nutm_pkg::*;

  localparam int TILE_W  = $clog2(MAX_TILES);
  localparam int TILE_CW = $clog2(MAX_TILES + 1);
  localparam int COMP_W  = $clog2(MAX_COMPONENTS);
  localparam int COMP_CW = $clog2(MAX_COMPONENTS + 1);
  localparam int DEPTH   = MAX_TILES * MAX_COMPONENTS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int ACC_W   = SUM_WIDTH + $clog2(MAX_COMPONENTS + 1);
  localparam int CMP_W   = (ACC_W > SCORE_W) ? ACC_W : SCORE_W;

  // Configuration registers
  logic [TILE_COUNT_W-1:0] tile_count;
  logic [COMP_COUNT_W-1:0] component_count;
  logic [SCORE_W-1:0]      score_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_count      <= RST_TILE_COUNT;
      component_count <= RST_COMP_COUNT;
      score_limit     <= RST_SCORE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TILE_COUNT:  tile_count      <= cfg_data[TILE_COUNT_W-1:0];
        CFG_COMP_COUNT:  component_count <= cfg_data[COMP_COUNT_W-1:0];
        CFG_SCORE_LIMIT: score_limit     <= cfg_data[SCORE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign tiles = (32'(tile_count) > MAX_TILES) ? TILE_CW'(MAX_TILES) : TILE_CW'(tile_count);
  assign comps = (32'(component_count) > MAX_COMPONENTS) ?
                 COMP_CW'(MAX_COMPONENTS) : COMP_CW'(component_count);

  // Store writes; out-of-range slots or components are dropped
  logic                 slot_ok;
  logic                 comp_ok;
  logic                 sig_we;
  logic                 qry_we;
  logic [ADDR_W-1:0]    sig_waddr;
  logic [ADDR_W-1:0]    sig_raddr;
  logic [SUM_WIDTH-1:0] wdata;
  logic [SUM_WIDTH-1:0] sig_rdata;
  logic [SUM_WIDTH-1:0] qry_rdata;

  assign slot_ok   = (32'(tile_slot) < MAX_TILES);
  assign comp_ok   = (32'(component_index) < MAX_COMPONENTS);
  assign sig_we    = cmd.accept && (op == OP_LOAD) && slot_ok && comp_ok;
  assign qry_we    = cmd.accept && (op == OP_QUERY) && comp_ok;
  assign wdata     = SUM_WIDTH'(value);
  assign sig_waddr = ADDR_W'(32'(tile_slot) * MAX_COMPONENTS + 32'(component_index));
  assign sig_raddr = ADDR_W'(32'(rd_tile) * MAX_COMPONENTS + 32'(rd_comp));

  nutm_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (DEPTH)
  ) u_sig_ram (
    .clk   (clk),
    .we    (sig_we),
    .waddr (sig_waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (sig_raddr),
    .rdata (sig_rdata)
  );

  nutm_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (MAX_COMPONENTS)
  ) u_qry_ram (
    .clk   (clk),
    .we    (qry_we),
    .waddr (COMP_W'(component_index)),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (rd_comp),
    .rdata (qry_rdata)
  );

  // Compare pipeline: read -> abs diff -> accumulate -> best update
  nutm_tag_t            p1, p2, p3;
  logic [TILE_W-1:0]    p1_tile, p2_tile, p3_tile;
  logic [SUM_WIDTH-1:0] diff;
  logic [ACC_W-1:0]     acc;
  logic [ACC_W-1:0]     acc_base;
  logic [SCORE_W-1:0]   best_score;
  logic [TILE_W-1:0]    best_index;
  logic                 best_found;
  logic                 better;
  logic [MAX_TILES-1:0] used;

  assign acc_base = p2.first ? '0 : acc;
  assign better   = (CMP_W'(acc) < CMP_W'(best_score));

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= '0;
      p2 <= '0;
      p3 <= '0;
    end else begin
      p1 <= '{valid: cmd.rd_en, first: cmd.first, last: cmd.last, zero: cmd.zero};
      p2 <= p1;
      p3 <= p2;
    end
  end

  always_ff @(posedge clk) begin
    p1_tile <= rd_tile;
    p2_tile <= p1_tile;
    p3_tile <= p2_tile;
    if (p1.zero) begin
      diff <= '0;
    end else if (qry_rdata >= sig_rdata) begin
      diff <= qry_rdata - sig_rdata;
    end else begin
      diff <= sig_rdata - qry_rdata;
    end
    if (p2.valid) begin
      acc <= acc_base + ACC_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_score <= '0;
      best_index <= '0;
      best_found <= 1'b0;
    end else if (cmd.start) begin
      best_score <= score_limit;
      best_index <= '0;
      best_found <= 1'b0;
    end else if (p3.valid && p3.last && better) begin
      // acc is below best here, so it fits the score width
      best_score <= SCORE_W'(acc);
      best_index <= p3_tile;
      best_found <= 1'b1;
    end
  end

  // Used marks and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      out_valid <= 1'b0;
      found     <= 1'b0;
      best_tile <= '0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
      found     <= best_found;
      best_tile <= TILE_SLOT_W'(best_index);
      if (best_found) begin
        used[best_index] <= 1'b1;
      end
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.used_cur = used[rd_tile];
  assign stat.busy     = p1.valid || p2.valid || p3.valid;
  assign stat.out_free = !out_valid || !out_stall;

endmodule

FILE: rtl/nutm_checker.sv
// Port-level checks for the nearest unused tile match block, bound to the top.
module nutm_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [nutm_pkg::OP_W-1:0]          op,
  input logic                               last,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               found,
  input logic [nutm_pkg::TILE_SLOT_W-1:0]   best_tile
);

  import nutm_pkg::*;

  // last query beat starts a search, which stalls input
  a_search_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_QUERY && last |=> in_stall)
    else $error("search did not stall input");

  // a load beat never starts a search
  a_load_no_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_LOAD |=> !in_stall)
    else $error("load beat stalled input");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> best_tile == '0)
    else $error("miss reported a nonzero tile");

  // results only appear at the end of a search
  a_result_from_search: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a search");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) && $stable(best_tile))
    else $error("stalled result beat changed");

endmodule

bind nearest_unused_tile_match nutm_checker u_nutm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .op        (op),
  .last      (last),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .found     (found),
  .best_tile (best_tile)
);
